// File: sv/orfp_pkg.sv
// orfp_pkg: shared constants, request codes and control structs for the
// overwrite ring fifo; no dependencies
package orfp_pkg;

	localparam int DEPTH     = 4096;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = AW + 1;
	localparam int MAX_BURST = 64;
	localparam int LW        = 7;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_PEEK  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_type_t;

	typedef struct packed {
		logic accept;
		logic issue;
	} dp_cmd_t;

	typedef struct packed {
		logic accept_ok;
		logic issue_ok;
		logic burst_start;
		logic last_issue;
	} dp_stat_t;

	typedef struct packed {
		logic [7:0]    data_out;
		logic          has_data;
		logic          is_last;
		logic [CW-1:0] fill_level;
	} rsp_t;

	function automatic logic [AW-1:0] next_slot(logic [AW-1:0] i, logic [CW-1:0] cap);
		logic [CW-1:0] s;
		s = CW'(i) + CW'(1);
		return (s >= cap) ? '0 : s[AW-1:0];
	endfunction

endpackage

// File: sv/orfp_ifs.sv
// orfp_ifs: request and response channel interfaces (valid/ready)
// depends on orfp_pkg for field widths
interface orfp_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  req_type;
	logic [7:0]                  data_byte;
	logic [orfp_pkg::LW-1:0]     request_length;
	logic [orfp_pkg::AW-1:0]     peek_offset;

	modport source (output valid, req_type, data_byte, request_length, peek_offset,
		input ready);
	modport sink (input valid, req_type, data_byte, request_length, peek_offset,
		output ready);
endinterface

interface orfp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  data_out;
	logic                        has_data;
	logic                        is_last;
	logic [orfp_pkg::CW-1:0]     fill_level;

	modport source (output valid, data_out, has_data, is_last, fill_level, input ready);
	modport sink (input valid, data_out, has_data, is_last, fill_level, output ready);
endinterface

// File: sv/orfp_dp.sv
// orfp_dp: byte store, ring pointers, fill count and two-entry response queue
// depends on orfp_pkg; driven by orfp_ctrl through dp_cmd_t / dp_stat_t
module orfp_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  orfp_pkg::dp_cmd_t         cmd,
	output orfp_pkg::dp_stat_t        stat,
	input  logic [1:0]                req_type,
	input  logic [7:0]                data_byte,
	input  logic [orfp_pkg::LW-1:0]   request_length,
	input  logic [orfp_pkg::AW-1:0]   peek_offset,
	input  logic                      cfg_we,
	input  logic [orfp_pkg::CW-1:0]   cfg_wdata,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output orfp_pkg::rsp_t            rsp_data
);

	logic [7:0]                byte_store_q [orfp_pkg::DEPTH];
	logic [orfp_pkg::CW-1:0]   cap_q;
	logic [orfp_pkg::AW-1:0]   head_q;
	logic [orfp_pkg::AW-1:0]   tail_q;
	logic [orfp_pkg::CW-1:0]   fill_q;
	logic [orfp_pkg::AW-1:0]   rdp_q;
	logic [orfp_pkg::LW-1:0]   cnt_q;
	logic                      is_read_q;
	logic                      inflight_q;
	logic [7:0]                rd_data_s1;
	logic                      last_s1;

	orfp_pkg::rsp_t            q_q [2];
	logic                      wp_q;
	logic                      rp_q;
	logic [1:0]                occ_q;

	orfp_pkg::req_type_t       rtype;
	logic [orfp_pkg::LW-1:0]   len_sat;
	logic [orfp_pkg::CW-1:0]   len_ext;
	logic [orfp_pkg::CW-1:0]   off_ext;
	logic [orfp_pkg::CW-1:0]   read_n;
	logic [orfp_pkg::CW-1:0]   avail;
	logic [orfp_pkg::CW-1:0]   peek_n;
	logic [orfp_pkg::CW-1:0]   req_n;
	logic [orfp_pkg::CW-1:0]   peek_sum;
	logic [orfp_pkg::CW-1:0]   peek_wrap;
	logic [orfp_pkg::CW-1:0]   cap_new;
	logic [orfp_pkg::CW-1:0]   direct_fill;
	logic [orfp_pkg::AW-1:0]   head_nx;
	logic [orfp_pkg::AW-1:0]   tail_nx;
	logic [orfp_pkg::AW-1:0]   rdp_nx;
	logic                      full;
	logic                      pop;
	logic                      direct_push;
	logic                      push;
	logic [2:0]                occ_sum;
	orfp_pkg::rsp_t            push_entry;

	assign rtype   = orfp_pkg::req_type_t'(req_type);
	assign len_sat = (request_length > orfp_pkg::LW'(orfp_pkg::MAX_BURST))
		? orfp_pkg::LW'(orfp_pkg::MAX_BURST) : request_length;
	assign len_ext = orfp_pkg::CW'(len_sat);
	assign off_ext = orfp_pkg::CW'(peek_offset);
	assign read_n  = (len_ext > fill_q) ? fill_q : len_ext;
	assign avail   = fill_q - off_ext;
	assign peek_n  = (off_ext < fill_q) ? ((len_ext > avail) ? avail : len_ext) : '0;

	always_comb begin
		case (rtype)
			orfp_pkg::REQ_READ: req_n = read_n;
			orfp_pkg::REQ_PEEK: req_n = peek_n;
			default:            req_n = '0;
		endcase
	end

	assign peek_sum  = orfp_pkg::CW'(tail_q) + off_ext;
	assign peek_wrap = (peek_sum >= cap_q) ? (peek_sum - cap_q) : peek_sum;

	assign head_nx = orfp_pkg::next_slot(head_q, cap_q);
	assign tail_nx = orfp_pkg::next_slot(tail_q, cap_q);
	assign rdp_nx  = orfp_pkg::next_slot(rdp_q, cap_q);
	assign full    = (fill_q >= cap_q);

	assign cap_new = (cfg_wdata == '0) ? orfp_pkg::CW'(1)
		: ((cfg_wdata > orfp_pkg::CW'(orfp_pkg::DEPTH)) ? orfp_pkg::CW'(orfp_pkg::DEPTH)
		: cfg_wdata);

	// response queue occupancy and flow
	assign rsp_valid = (occ_q != 2'd0);
	assign rsp_data  = q_q[rp_q];
	assign pop       = rsp_valid && rsp_ready;
	assign occ_sum   = 3'(occ_q) + 3'(inflight_q);

	assign stat.accept_ok   = !inflight_q && (3'(occ_q) <= (3'd1 + 3'(pop)));
	assign stat.issue_ok    = (occ_sum <= (3'd1 + 3'(pop)));
	assign stat.burst_start = (req_n != '0);
	assign stat.last_issue  = (cnt_q == orfp_pkg::LW'(1));

	always_comb begin
		case (rtype)
			orfp_pkg::REQ_WRITE: direct_fill = full ? fill_q : (fill_q + orfp_pkg::CW'(1));
			orfp_pkg::REQ_CLEAR: direct_fill = '0;
			default:             direct_fill = fill_q;
		endcase
	end

	assign direct_push = cmd.accept && !stat.burst_start;
	assign push        = direct_push || inflight_q;

	always_comb begin
		if (inflight_q) begin
			push_entry = '{data_out: rd_data_s1, has_data: 1'b1, is_last: last_s1,
				fill_level: fill_q};
		end else begin
			push_entry = '{data_out: 8'd0, has_data: 1'b0, is_last: 1'b1,
				fill_level: direct_fill};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= orfp_pkg::CW'(orfp_pkg::DEPTH);
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
			rdp_q      <= '0;
			cnt_q      <= '0;
			is_read_q  <= 1'b0;
			inflight_q <= 1'b0;
			wp_q       <= 1'b0;
			rp_q       <= 1'b0;
			occ_q      <= 2'd0;
		end else begin
			inflight_q <= cmd.issue;
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push) begin
				wp_q <= ~wp_q;
			end
			occ_q <= occ_q + 2'(push) - 2'(pop);
			if (cfg_we) begin
				cap_q  <= cap_new;
				head_q <= '0;
				tail_q <= '0;
				fill_q <= '0;
			end else if (cmd.accept) begin
				case (rtype)
					orfp_pkg::REQ_WRITE: begin
						head_q <= head_nx;
						if (full) begin
							tail_q <= tail_nx;
						end else begin
							fill_q <= fill_q + orfp_pkg::CW'(1);
						end
					end
					orfp_pkg::REQ_READ: begin
						fill_q    <= fill_q - read_n;
						rdp_q     <= tail_q;
						cnt_q     <= req_n[orfp_pkg::LW-1:0];
						is_read_q <= 1'b1;
					end
					orfp_pkg::REQ_PEEK: begin
						rdp_q     <= peek_wrap[orfp_pkg::AW-1:0];
						cnt_q     <= req_n[orfp_pkg::LW-1:0];
						is_read_q <= 1'b0;
					end
					default: begin
						head_q <= '0;
						tail_q <= '0;
						fill_q <= '0;
					end
				endcase
			end else if (cmd.issue) begin
				rdp_q <= rdp_nx;
				cnt_q <= cnt_q - orfp_pkg::LW'(1);
				if (is_read_q) begin
					tail_q <= rdp_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= push_entry;
		end
		if (cmd.accept && (rtype == orfp_pkg::REQ_WRITE)) begin
			byte_store_q[head_q] <= data_byte;
		end
		if (cmd.issue) begin
			rd_data_s1 <= byte_store_q[rdp_q];
			last_s1    <= stat.last_issue;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) occ_q != 2'd3)
		else $error("response queue occupancy out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (occ_q != 2'd2))
		else $error("response queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		direct_push |-> !inflight_q)
		else $error("direct result collides with memory return");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= cap_q) && (orfp_pkg::CW'(head_q) < cap_q)
		&& (orfp_pkg::CW'(tail_q) < cap_q))
		else $error("ring state outside capacity");

endmodule

// File: sv/orfp_ctrl.sv
// orfp_ctrl: request sequencer; accepts requests and steps byte bursts
// depends on orfp_pkg; commands orfp_dp
module orfp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output orfp_pkg::dp_cmd_t     cmd,
	input  orfp_pkg::dp_stat_t    stat
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_BURST = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.issue  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = stat.accept_ok;
				cmd.accept = in_valid && stat.accept_ok;
				if (cmd.accept && stat.burst_start) begin
					state_d = ST_BURST;
				end
			end
			ST_BURST: begin
				cmd.issue = stat.issue_ok;
				if (cmd.issue && stat.last_issue) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && stat.burst_start) |=> (state_q == ST_BURST) && !in_ready)
		else $error("burst request did not start a burst");

endmodule

// File: sv/overwrite_ring_fifo_with_peek.sv
// overwrite_ring_fifo_with_peek: top level of the byte ring buffer
// depends on orfp_pkg, orfp_ifs, orfp_ctrl and orfp_dp
//
// usage: requests arrive on req (valid/ready): write one byte, read and remove
// up to request_length bytes, peek from peek_offset past the oldest byte, or
// clear. results leave on rsp (valid/ready), one per byte emitted, or one with
// has_data low for a request that emits nothing; is_last marks the final one
// and fill_level gives the fill after the whole request.
// cfg_we/cfg_wdata set the capacity in use (clamped to 1..4096) and empty the
// buffer; write it only while no request is outstanding.
// a write, clear or empty request has its result registered into the response queue
// when it is taken; a read or peek is accepted, then issues its bytes from the
// registered read port of the byte store into the response queue. writes are
// taken one per cycle while the response queue has room.
// no new request is taken while a burst is running.
// a two-entry response queue keeps requests flowing while rsp is stalled; a
// burst pauses when the queue is full. after reset the buffer is empty and the
// capacity is 4096; the byte store needs no clearing.
module overwrite_ring_fifo_with_peek (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [orfp_pkg::CW-1:0] cfg_wdata,
	orfp_req_if.sink                req,
	orfp_rsp_if.source              rsp
);

	orfp_pkg::dp_cmd_t  cmd;
	orfp_pkg::dp_stat_t stat;
	orfp_pkg::rsp_t     rsp_data;

	orfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	orfp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_type       (req.req_type),
		.data_byte      (req.data_byte),
		.request_length (req.request_length),
		.peek_offset    (req.peek_offset),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_data       (rsp_data)
	);

	assign rsp.data_out   = rsp_data.data_out;
	assign rsp.has_data   = rsp_data.has_data;
	assign rsp.is_last    = rsp_data.is_last;
	assign rsp.fill_level = rsp_data.fill_level;

endmodule

// File: dv/overwrite_ring_fifo_with_peek_tb.sv
`timescale 1ns / 1ps
// overwrite_ring_fifo_with_peek_tb: self-checking bench for the byte ring buffer
// drives write/read/peek/clear requests over several capacities and checks every result
// depends on orfp_pkg, orfp_ifs and the overwrite_ring_fifo_with_peek rtl
module overwrite_ring_fifo_with_peek_tb;

	typedef struct packed {
		orfp_pkg::req_type_t     req_type;
		logic [7:0]              data_byte;
		logic [orfp_pkg::LW-1:0] request_length;
		logic [orfp_pkg::AW-1:0] peek_offset;
	} ring_req_t;

	localparam int unsigned N_CAPS = 7;
	localparam int unsigned CAP_PLAN [N_CAPS] = '{1, 2, 7, 0, 64, 8191, 4096};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [orfp_pkg::CW-1:0] cfg_wdata;

	orfp_req_if req_bus ();
	orfp_rsp_if rsp_bus ();

	overwrite_ring_fifo_with_peek i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// shadow of the ring contents and pointers
	logic [7:0]  ring_mem [orfp_pkg::DEPTH];
	int unsigned ring_head = 0;
	int unsigned ring_tail = 0;
	int unsigned ring_fill = 0;
	int unsigned ring_cap  = orfp_pkg::DEPTH;

	ring_req_t       req_backlog [$];
	orfp_pkg::rsp_t  rsp_due [$];
	int unsigned     mismatches = 0;
	int unsigned     gen_fill = 0;
	int unsigned     burst_left = 0;
	int unsigned     gap_left = 0;
	logic [15:0]     stall_pat;
	logic [15:0]     stall_next;
	int unsigned     stall_age;

	function automatic int unsigned ring_next(input int unsigned pos);
		return (pos + 1 >= ring_cap) ? 0 : pos + 1;
	endfunction

	// applies one request to the shadow ring and queues the bytes it should emit
	function automatic void ring_respond(input ring_req_t rq);
		int unsigned    want;
		int unsigned    n;
		int unsigned    pos;
		int unsigned    k;
		orfp_pkg::rsp_t r;
		want = (rq.request_length > orfp_pkg::MAX_BURST) ? orfp_pkg::MAX_BURST
			: rq.request_length;
		n = 0;
		pos = ring_tail;
		case (rq.req_type)
			orfp_pkg::REQ_WRITE: begin
				ring_mem[ring_head] = rq.data_byte;
				ring_head = ring_next(ring_head);
				if (ring_fill < ring_cap)
					ring_fill++;
				else
					ring_tail = ring_next(ring_tail);
			end
			orfp_pkg::REQ_READ: begin
				n = (want > ring_fill) ? ring_fill : want;
				ring_fill -= n;
				for (k = 0; k < n; k++)
					ring_tail = ring_next(ring_tail);
			end
			orfp_pkg::REQ_PEEK: begin
				if (rq.peek_offset < ring_fill) begin
					n = ring_fill - rq.peek_offset;
					if (n > want)
						n = want;
					pos = ring_tail + rq.peek_offset;
					if (pos >= ring_cap)
						pos -= ring_cap;
				end
			end
			default: begin
				ring_head = 0;
				ring_tail = 0;
				ring_fill = 0;
			end
		endcase
		for (k = 0; k < n; k++) begin
			r.data_out   = ring_mem[pos];
			r.has_data   = 1'b1;
			r.is_last    = (k + 1 == n);
			r.fill_level = orfp_pkg::CW'(ring_fill);
			rsp_due.push_back(r);
			pos = ring_next(pos);
		end
		if (n == 0)
			rsp_due.push_back('{data_out: 8'h00, has_data: 1'b0, is_last: 1'b1,
				fill_level: orfp_pkg::CW'(ring_fill)});
	endfunction

	function automatic ring_req_t dir_req(input orfp_pkg::req_type_t kind,
		input logic [7:0] data, input logic [orfp_pkg::LW-1:0] len,
		input logic [orfp_pkg::AW-1:0] offset);
		return '{req_type: kind, data_byte: data, request_length: len, peek_offset: offset};
	endfunction

	// random request aimed at the current fill; gen_fill follows the planned sequence
	function automatic ring_req_t random_request(input bit write_only);
		ring_req_t   rq;
		int unsigned pick;
		int unsigned len_top;
		int unsigned want;
		pick = $urandom_range(0, 99);
		if (write_only || pick < 50)
			rq.req_type = orfp_pkg::REQ_WRITE;
		else if (pick < 70)
			rq.req_type = orfp_pkg::REQ_READ;
		else if (pick < 93)
			rq.req_type = orfp_pkg::REQ_PEEK;
		else
			rq.req_type = orfp_pkg::REQ_CLEAR;
		rq.data_byte = 8'($urandom_range(0, 255));
		len_top = (gen_fill + 2 > orfp_pkg::MAX_BURST) ? orfp_pkg::MAX_BURST : gen_fill + 2;
		case ($urandom_range(0, 9))
			0: rq.request_length = orfp_pkg::LW'($urandom_range(orfp_pkg::MAX_BURST + 1, 127));
			1: rq.request_length = orfp_pkg::LW'($urandom_range(0, 127));
			default: rq.request_length = orfp_pkg::LW'($urandom_range(0, len_top));
		endcase
		if ($urandom_range(0, 3) == 0)
			rq.peek_offset = orfp_pkg::AW'($urandom_range(0, orfp_pkg::DEPTH - 1));
		else
			rq.peek_offset = orfp_pkg::AW'($urandom_range(0, gen_fill));
		want = (rq.request_length > orfp_pkg::MAX_BURST) ? orfp_pkg::MAX_BURST
			: rq.request_length;
		case (rq.req_type)
			orfp_pkg::REQ_WRITE: if (gen_fill < ring_cap) gen_fill++;
			orfp_pkg::REQ_READ: gen_fill -= (want > gen_fill) ? gen_fill : want;
			orfp_pkg::REQ_CLEAR: gen_fill = 0;
			default: ;
		endcase
		return rq;
	endfunction

	function automatic void check_field(input string fname, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			mismatches++;
		end
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (req_backlog.size() != 0 || req_bus.valid || rsp_due.size() != 0);
		repeat (10) @(negedge clk);
	endtask

	// request driver: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin : req_driver
		ring_req_t seen;
		ring_req_t next_req;
		if (!arst_n) begin
			req_bus.valid          <= 1'b0;
			req_bus.req_type       <= orfp_pkg::REQ_WRITE;
			req_bus.data_byte      <= '0;
			req_bus.request_length <= '0;
			req_bus.peek_offset    <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				seen.req_type       = orfp_pkg::req_type_t'(req_bus.req_type);
				seen.data_byte      = req_bus.data_byte;
				seen.request_length = req_bus.request_length;
				seen.peek_offset    = req_bus.peek_offset;
				ring_respond(seen);
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (gap_left != 0 || req_backlog.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					req_bus.valid <= 1'b0;
				end else begin
					next_req = req_backlog.pop_front();
					req_bus.valid          <= 1'b1;
					req_bus.req_type       <= next_req.req_type;
					req_bus.data_byte      <= next_req.data_byte;
					req_bus.request_length <= next_req.request_length;
					req_bus.peek_offset    <= next_req.peek_offset;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// response stall pattern: rotating 16-bit mask, re-picked when its age count runs out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			stall_pat     <= '1;
			stall_age     <= 0;
		end else begin
			if (stall_age == 0) begin
				case ($urandom_range(0, 3))
					0: stall_next = '1;
					1: stall_next = 16'($urandom) | 16'h0001;
					2: stall_next = 16'h0001 << $urandom_range(0, 15);
					default: stall_next = ~(16'h0001 << $urandom_range(0, 15));
				endcase
				stall_age <= $urandom_range(16, 96);
			end else begin
				stall_next = {stall_pat[0], stall_pat[15:1]};
				stall_age <= stall_age - 1;
			end
			stall_pat     <= stall_next;
			rsp_bus.ready <= stall_next[0];
		end
	end

	always @(posedge clk) begin : rsp_monitor
		orfp_pkg::rsp_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (rsp_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual data %0h has %0b last %0b fill %0d",
					$time, rsp_bus.data_out, rsp_bus.has_data, rsp_bus.is_last, rsp_bus.fill_level);
				mismatches++;
			end else begin
				want = rsp_due.pop_front();
				check_field("data_out", 16'(want.data_out), 16'(rsp_bus.data_out));
				check_field("has_data", 16'(want.has_data), 16'(rsp_bus.has_data));
				check_field("is_last", 16'(want.is_last), 16'(rsp_bus.is_last));
				check_field("fill_level", 16'(want.fill_level), 16'(rsp_bus.fill_level));
			end
		end
	end

	initial begin : stimulus
		int unsigned fill_n;
		int unsigned cap_val;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty buffer, saturation, zero length, peek at and past the fill, clear
		req_backlog.push_back(dir_req(orfp_pkg::REQ_READ, 8'h00, 7'd5, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_PEEK, 8'h00, 7'd5, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_WRITE, 8'h00, 7'd0, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_WRITE, 8'hFF, 7'd127, 12'd4095));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_WRITE, 8'hA5, 7'd0, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_WRITE, 8'h5A, 7'd0, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_PEEK, 8'h00, 7'd0, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_READ, 8'h00, 7'd0, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_PEEK, 8'h00, 7'd127, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_PEEK, 8'h00, 7'd64, 12'd3));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_PEEK, 8'h00, 7'd1, 12'd4));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_PEEK, 8'h00, 7'd64, 12'd4095));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_READ, 8'h00, 7'd1, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_READ, 8'h00, 7'd127, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_READ, 8'h00, 7'd64, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_WRITE, 8'h3C, 7'd0, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_WRITE, 8'hC3, 7'd0, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_CLEAR, 8'hFF, 7'd127, 12'd4095));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_READ, 8'h00, 7'd2, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_WRITE, 8'h81, 7'd0, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_PEEK, 8'h00, 7'd1, 12'd0));
		req_backlog.push_back(dir_req(orfp_pkg::REQ_READ, 8'h00, 7'd64, 12'd0));

		for (int p = 0; p < N_CAPS; p++) begin
			wait_drained();
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_wdata <= orfp_pkg::CW'(CAP_PLAN[p]);
			cap_val = CAP_PLAN[p];
			ring_cap = (cap_val == 0) ? 1
				: ((cap_val > orfp_pkg::DEPTH) ? orfp_pkg::DEPTH : cap_val);
			ring_head = 0;
			ring_tail = 0;
			ring_fill = 0;
			@(posedge clk);
			cfg_we <= 1'b0;
			@(negedge clk);
			gen_fill = 0;
			// fill past capacity on small rings so the overwrite path is hit
			fill_n = (ring_cap <= 8) ? ring_cap + $urandom_range(1, 3) : 6;
			repeat (fill_n) req_backlog.push_back(random_request(1'b1));
			repeat (9) req_backlog.push_back(random_request(1'b0));
		end

		wait_drained();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#40ms;
		$display("%0t: timeout", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
